>>> design/tba_pkg.sv
`default_nettype none

package tba_pkg;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 11;
  localparam int POS_W    = 10;
  localparam int STRIDE_W = 13;
  localparam int CFG_IDX_W = 3;

  // Largest wrap size the column and row counters can follow
  localparam logic [SIZE_W-1:0] MAX_WRAP = 11'd1024;

  // Request codes
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STRIDE = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0]   dest_base;
    logic [ADDR_W-1:0]   source_base;
    logic [SIZE_W-1:0]   source_width;
    logic [SIZE_W-1:0]   source_height;
    logic [STRIDE_W-1:0] source_stride;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [POS_W-1:0]  dest_x;
    logic [POS_W-1:0]  dest_y;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
    logic [POS_W-1:0]  offset_x;
    logic [POS_W-1:0]  offset_y;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] source_addr;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> design/tba_walker.sv
`default_nettype none

module tba_walker #(
  parameter int FB_ROW_BYTES = 256
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                take,
  input  wire tba_pkg::req_t req,
  input  wire tba_pkg::cfg_t cfg,
  output tba_pkg::res_t      res,
  output logic               active
);

  localparam int ROW_W = $clog2(FB_ROW_BYTES + 1);
  localparam int DOFF_W = tba_pkg::POS_W + ROW_W;
  localparam int SOFF_W = tba_pkg::POS_W + tba_pkg::STRIDE_W;
  localparam int SW = tba_pkg::SIZE_W;
  localparam int PW = tba_pkg::POS_W;
  localparam int AW = tba_pkg::ADDR_W;

  // Walk state
  logic [SW-1:0] col_count, row_count, latched_width, latched_height;
  logic [PW-1:0] source_col, start_col, source_row;
  logic [AW-1:0] dest_line_addr, source_line_addr;
  logic          active_next;
  logic [SW-1:0] col_count_next, row_count_next, latched_width_next, latched_height_next;
  logic [PW-1:0] source_col_next, start_col_next, source_row_next;
  logic [AW-1:0] dest_line_addr_next, source_line_addr_next;

  logic [SW-1:0]     w_eff, h_eff;
  logic              start_ok, row_end, is_last;
  logic [SW:0]       col_p1, row_p1;
  logic [SW-1:0]     scol_p1, srow_p1;
  logic [DOFF_W-1:0] dest_row_off;
  logic [SOFF_W-1:0] source_row_off;

  // Wrap sizes clamp at the counter range
  assign w_eff = (cfg.source_width > tba_pkg::MAX_WRAP) ? tba_pkg::MAX_WRAP : cfg.source_width;
  assign h_eff = (cfg.source_height > tba_pkg::MAX_WRAP) ? tba_pkg::MAX_WRAP : cfg.source_height;

  assign start_ok = ({1'b0, req.offset_x} < w_eff) && ({1'b0, req.offset_y} < h_eff);

  // Line offsets for a start word
  assign dest_row_off   = DOFF_W'(req.dest_y) * DOFF_W'(FB_ROW_BYTES);
  assign source_row_off = SOFF_W'(req.offset_y) * SOFF_W'(cfg.source_stride);

  // End-of-row and end-of-blit tests
  assign col_p1  = {1'b0, col_count} + 1'b1;
  assign row_p1  = {1'b0, row_count} + 1'b1;
  assign row_end = col_p1 >= {1'b0, latched_width};
  assign is_last = row_end && (row_p1 >= {1'b0, latched_height});
  assign scol_p1 = {1'b0, source_col} + 1'b1;
  assign srow_p1 = {1'b0, source_row} + 1'b1;

  // Result for an advance word
  always_comb begin
    res.valid       = take && (req.req_type == tba_pkg::REQ_ADVANCE) && active;
    res.dest_addr   = dest_line_addr + AW'(col_count);
    res.source_addr = source_line_addr + AW'(source_col);
    res.last        = is_last;
  end

  // Next walk state
  always_comb begin
    active_next           = active;
    col_count_next        = col_count;
    row_count_next        = row_count;
    latched_width_next    = latched_width;
    latched_height_next   = latched_height;
    source_col_next       = source_col;
    start_col_next        = start_col;
    source_row_next       = source_row;
    dest_line_addr_next   = dest_line_addr;
    source_line_addr_next = source_line_addr;
    if (take && req.req_type == tba_pkg::REQ_START && start_ok) begin
      latched_width_next    = req.rect_width;
      latched_height_next   = req.rect_height;
      col_count_next        = '0;
      row_count_next        = '0;
      start_col_next        = req.offset_x;
      source_col_next       = req.offset_x;
      source_row_next       = req.offset_y;
      dest_line_addr_next   = cfg.dest_base + AW'(req.dest_x) + AW'(dest_row_off);
      source_line_addr_next = cfg.source_base + AW'(source_row_off);
      active_next           = (req.rect_width != '0) && (req.rect_height != '0);
    end else if (res.valid) begin
      if (is_last) begin
        active_next = 1'b0;
      end else if (row_end) begin
        col_count_next      = '0;
        row_count_next      = row_p1[SW-1:0];
        source_col_next     = start_col;
        dest_line_addr_next = dest_line_addr + AW'(FB_ROW_BYTES);
        if (srow_p1 >= h_eff) begin
          source_row_next       = '0;
          source_line_addr_next = cfg.source_base;
        end else begin
          source_row_next       = srow_p1[PW-1:0];
          source_line_addr_next = source_line_addr + AW'(cfg.source_stride);
        end
      end else begin
        col_count_next  = col_p1[SW-1:0];
        source_col_next = (scol_p1 >= w_eff) ? '0 : scol_p1[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      col_count        <= '0;
      row_count        <= '0;
      latched_width    <= '0;
      latched_height   <= '0;
      source_col       <= '0;
      start_col        <= '0;
      source_row       <= '0;
      dest_line_addr   <= '0;
      source_line_addr <= '0;
    end else begin
      active           <= active_next;
      col_count        <= col_count_next;
      row_count        <= row_count_next;
      latched_width    <= latched_width_next;
      latched_height   <= latched_height_next;
      source_col       <= source_col_next;
      start_col        <= start_col_next;
      source_row       <= source_row_next;
      dest_line_addr   <= dest_line_addr_next;
      source_line_addr <= source_line_addr_next;
    end
  end

endmodule

`default_nettype wire

>>> design/tiled_blit_address_generator.sv
`default_nettype none

// Tiled blit address generator.
// Input channel (in_valid/in_ready): a start word latches the rectangle and
// source offsets; each advance word yields one destination/source byte
// address pair, row by row, with last set on the final pair. A start, an
// advance while no blit runs, and a start whose offsets fall outside the
// bitmap give no output word.
// Output channel (out_valid/out_ready): one output register. A pair shows
// on the output ports the cycle after its advance word is taken.
// Throughput: one word per cycle. All walk updates are combinational logic
// (one 10x13 multiply and adds on a start) into the walk registers.
// When the receiver stalls with a word pending, in_ready drops until it is
// taken; in_ready is high whenever the output register is empty or drains.
// Configuration (cfg_valid/cfg_ready) is always ready and is meant to be
// written only while the block is idle.
// Reset clears the walk state and output valid, and loads the register
// defaults: bases zero, width, height and stride one.
module tiled_blit_address_generator #(
  parameter int FB_ROW_BYTES = 256
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 req_type,
  input  wire  [tba_pkg::POS_W-1:0]           dest_x,
  input  wire  [tba_pkg::POS_W-1:0]           dest_y,
  input  wire  [tba_pkg::SIZE_W-1:0]          rect_width,
  input  wire  [tba_pkg::SIZE_W-1:0]          rect_height,
  input  wire  [tba_pkg::POS_W-1:0]           offset_x,
  input  wire  [tba_pkg::POS_W-1:0]           offset_y,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [tba_pkg::ADDR_W-1:0]          dest_addr,
  output logic [tba_pkg::ADDR_W-1:0]          source_addr,
  output logic                                last,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [tba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [tba_pkg::ADDR_W-1:0]          cfg_data
);

  tba_pkg::cfg_t cfg;
  tba_pkg::req_t req;
  tba_pkg::res_t res;
  logic          take;
  logic          walk_active;
  logic          out_valid_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  always_comb begin
    req.req_type    = req_type;
    req.dest_x      = dest_x;
    req.dest_y      = dest_y;
    req.rect_width  = rect_width;
    req.rect_height = rect_height;
    req.offset_x    = offset_x;
    req.offset_y    = offset_y;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_base     <= '0;
      cfg.source_base   <= '0;
      cfg.source_width  <= tba_pkg::SIZE_W'(1);
      cfg.source_height <= tba_pkg::SIZE_W'(1);
      cfg.source_stride <= tba_pkg::STRIDE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tba_pkg::CFG_DEST_BASE:     cfg.dest_base     <= cfg_data;
        tba_pkg::CFG_SOURCE_BASE:   cfg.source_base   <= cfg_data;
        tba_pkg::CFG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data[tba_pkg::SIZE_W-1:0];
        tba_pkg::CFG_SOURCE_HEIGHT: cfg.source_height <= cfg_data[tba_pkg::SIZE_W-1:0];
        tba_pkg::CFG_SOURCE_STRIDE: cfg.source_stride <= cfg_data[tba_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  tba_walker #(
    .FB_ROW_BYTES (FB_ROW_BYTES)
  ) u_walker (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .req    (req),
    .cfg    (cfg),
    .res    (res),
    .active (walk_active)
  );

  // Output register
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (res.valid) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      dest_addr   <= res.dest_addr;
      source_addr <= res.source_addr;
      last        <= res.last;
    end
  end

  // A start word never leaves an output word behind it
  a_start_no_out: assert property (@(posedge clk) disable iff (rst)
    take && req_type == tba_pkg::REQ_START |=> !out_valid)
    else $error("output word after start");

  // An advance with no blit running gives nothing
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    take && req_type == tba_pkg::REQ_ADVANCE && !walk_active |=> !out_valid)
    else $error("output word while idle");

  // The last pair ends the blit
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |=> !walk_active && out_valid && last)
    else $error("blit still active after last pair");

  // An accepted advance during a blit always yields a word
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    take && req_type == tba_pkg::REQ_ADVANCE && walk_active |=> out_valid)
    else $error("advance lost");

endmodule

`default_nettype wire

>>> tb/sv/blit_pair_checker.sv
`timescale 1ns / 1ps

// Follows the blit walk from the words taken on the input and register
// channels, queues the address pair each advance should give, and checks
// every pair taken on the output channel against the oldest queued one.
module blit_pair_checker #(
  parameter int FB_ROW_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          req_type,
  input  logic [tba_pkg::POS_W-1:0]     dest_x,
  input  logic [tba_pkg::POS_W-1:0]     dest_y,
  input  logic [tba_pkg::SIZE_W-1:0]    rect_width,
  input  logic [tba_pkg::SIZE_W-1:0]    rect_height,
  input  logic [tba_pkg::POS_W-1:0]     offset_x,
  input  logic [tba_pkg::POS_W-1:0]     offset_y,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tba_pkg::ADDR_W-1:0]    dest_addr,
  input  logic [tba_pkg::ADDR_W-1:0]    source_addr,
  input  logic                          last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tba_pkg::ADDR_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            pending
);
  localparam int ADDR_W   = tba_pkg::ADDR_W;
  localparam int SIZE_W   = tba_pkg::SIZE_W;
  localparam int POS_W    = tba_pkg::POS_W;
  localparam int STRIDE_W = tba_pkg::STRIDE_W;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] source;
    logic              is_last;
  } addr_pair_t;

  // register copy
  logic [ADDR_W-1:0]   dest_base_q;
  logic [ADDR_W-1:0]   source_base_q;
  logic [SIZE_W-1:0]   src_width_q;
  logic [SIZE_W-1:0]   src_height_q;
  logic [STRIDE_W-1:0] src_stride_q;

  // walk state
  logic              walking;
  logic [SIZE_W-1:0] col_cnt, row_cnt, rect_w, rect_h;
  logic [POS_W-1:0]  src_col, first_col, src_row;
  logic [ADDR_W-1:0] dest_line, src_line;

  addr_pair_t expected_pairs[$];
  int         fail_total = 0;

  // wrap sizes above what the 10-bit counters can follow act as the maximum
  function automatic logic [SIZE_W-1:0] wrap_size(input logic [SIZE_W-1:0] v);
    return (v > tba_pkg::MAX_WRAP) ? tba_pkg::MAX_WRAP : v;
  endfunction

  task automatic clear_state();
    dest_base_q   = '0;
    source_base_q = '0;
    src_width_q   = SIZE_W'(1);
    src_height_q  = SIZE_W'(1);
    src_stride_q  = STRIDE_W'(1);
    walking   = 1'b0;
    col_cnt   = '0;
    row_cnt   = '0;
    rect_w    = '0;
    rect_h    = '0;
    src_col   = '0;
    first_col = '0;
    src_row   = '0;
    dest_line = '0;
    src_line  = '0;
    expected_pairs.delete();
  endtask

  task automatic check_pair();
    addr_pair_t want;
    if (expected_pairs.size() == 0) begin
      fail_total++;
      $display("%0t: pair with none expected: dest %h source %h last %b",
               $time, dest_addr, source_addr, last);
    end else begin
      want = expected_pairs.pop_front();
      if (dest_addr !== want.dest) begin
        fail_total++;
        $display("%0t: dest_addr expected %h, got %h", $time, want.dest, dest_addr);
      end
      if (source_addr !== want.source) begin
        fail_total++;
        $display("%0t: source_addr expected %h, got %h", $time, want.source, source_addr);
      end
      if (last !== want.is_last) begin
        fail_total++;
        $display("%0t: last expected %b, got %b", $time, want.is_last, last);
      end
    end
  endtask

  // one input word: a start latches a new walk, an advance during a walk emits one pair
  task automatic take_request();
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic              row_end, fin;
    addr_pair_t        pair;
    w_eff = wrap_size(src_width_q);
    h_eff = wrap_size(src_height_q);
    if (req_type == tba_pkg::REQ_START) begin
      // offsets outside the bitmap: the word is dropped, any walk goes on
      if ({1'b0, offset_x} < w_eff && {1'b0, offset_y} < h_eff) begin
        rect_w    = rect_width;
        rect_h    = rect_height;
        col_cnt   = '0;
        row_cnt   = '0;
        first_col = offset_x;
        src_col   = offset_x;
        src_row   = offset_y;
        dest_line = dest_base_q + ADDR_W'(dest_x) + ADDR_W'(dest_y) * ADDR_W'(FB_ROW_BYTES);
        src_line  = source_base_q + ADDR_W'(offset_y) * ADDR_W'(src_stride_q);
        walking   = (rect_width != '0) && (rect_height != '0);
      end
    end else if (walking) begin
      row_end = (12'(col_cnt) + 12'd1) >= 12'(rect_w);
      fin     = row_end && ((12'(row_cnt) + 12'd1) >= 12'(rect_h));
      pair.dest    = dest_line + ADDR_W'(col_cnt);
      pair.source  = src_line + ADDR_W'(src_col);
      pair.is_last = fin;
      expected_pairs.push_back(pair);
      if (fin) begin
        walking = 1'b0;
      end else if (row_end) begin
        col_cnt   = '0;
        row_cnt   = row_cnt + 1'b1;
        src_col   = first_col;
        dest_line = dest_line + ADDR_W'(FB_ROW_BYTES);
        // vertical wrap goes back to the bitmap's top line
        if ((SIZE_W'(src_row) + 1'b1) >= h_eff) begin
          src_row  = '0;
          src_line = source_base_q;
        end else begin
          src_row  = src_row + 1'b1;
          src_line = src_line + ADDR_W'(src_stride_q);
        end
      end else begin
        col_cnt = col_cnt + 1'b1;
        src_col = ((SIZE_W'(src_col) + 1'b1) >= w_eff) ? '0 : src_col + 1'b1;
      end
    end
  endtask

  task automatic apply_reg_write();
    case (cfg_index)
      tba_pkg::CFG_DEST_BASE:     dest_base_q   = cfg_data;
      tba_pkg::CFG_SOURCE_BASE:   source_base_q = cfg_data;
      tba_pkg::CFG_SOURCE_WIDTH:  src_width_q   = cfg_data[SIZE_W-1:0];
      tba_pkg::CFG_SOURCE_HEIGHT: src_height_q  = cfg_data[SIZE_W-1:0];
      tba_pkg::CFG_SOURCE_STRIDE: src_stride_q  = cfg_data[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  // output first: a pair taken this cycle belongs to an earlier advance
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (out_valid && out_ready) check_pair();
      if (in_valid && in_ready) take_request();
      if (cfg_valid && cfg_ready) apply_reg_write();
    end
    mismatches <= fail_total;
    pending    <= expected_pairs.size();
  end

endmodule

>>> tb/sv/tiled_blit_address_generator_test.sv
`timescale 1ns / 1ps

module tiled_blit_address_generator_test;

  localparam int FB_ROW_BYTES  = 256;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_WORDS   = 92;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_BLIT     = 40;

  localparam int POS_W     = tba_pkg::POS_W;
  localparam int SIZE_W    = tba_pkg::SIZE_W;
  localparam int ADDR_W    = tba_pkg::ADDR_W;
  localparam int CFG_IDX_W = tba_pkg::CFG_IDX_W;

  // index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 req_type;
  logic [POS_W-1:0]     dest_x, dest_y, offset_x, offset_y;
  logic [SIZE_W-1:0]    rect_width, rect_height;
  logic                 out_valid;
  logic                 out_ready;
  logic [ADDR_W-1:0]    dest_addr, source_addr;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  int mismatches;
  int pending;

  // stimulus side state
  logic jitter_on;
  int   hold_requests;
  int   cur_w, cur_h;

  tiled_blit_address_generator #(
    .FB_ROW_BYTES(FB_ROW_BYTES)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .dest_x(dest_x), .dest_y(dest_y),
    .rect_width(rect_width), .rect_height(rect_height),
    .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .dest_addr(dest_addr), .source_addr(source_addr), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  blit_pair_checker #(
    .FB_ROW_BYTES(FB_ROW_BYTES)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .dest_x(dest_x), .dest_y(dest_y),
    .rect_width(rect_width), .rect_height(rect_height),
    .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .dest_addr(dest_addr), .source_addr(source_addr), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
        out_ready <= 1'b1;
      end else begin
        out_ready <= !(jitter_on && $urandom_range(99) < 12);
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tiled_blit_address_generator_test NOT OK");
    $finish;
  end

  // all drive tasks start and end right after a rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic program_regs(input logic [ADDR_W-1:0] db, sb, input int w, h, stride);
    write_reg(tba_pkg::CFG_DEST_BASE, db);
    write_reg(tba_pkg::CFG_SOURCE_BASE, sb);
    write_reg(tba_pkg::CFG_SOURCE_WIDTH, ($urandom & ~32'h7FF) | (w & 32'h7FF));
    write_reg(tba_pkg::CFG_SOURCE_HEIGHT, ($urandom & ~32'h7FF) | (h & 32'h7FF));
    write_reg(tba_pkg::CFG_SOURCE_STRIDE, ($urandom & ~32'h1FFF) | (stride & 32'h1FFF));
    write_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
    cur_w = ((w & 'h7FF) > 1024) ? 1024 : (w & 'h7FF);
    cur_h = ((h & 'h7FF) > 1024) ? 1024 : (h & 'h7FF);
  endtask

  task automatic send_word(input logic kind, input logic [POS_W-1:0] dx, dy,
                           input logic [SIZE_W-1:0] rw, rh,
                           input logic [POS_W-1:0] ox, oy);
    if (jitter_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    dest_x      <= dx;
    dest_y      <= dy;
    rect_width  <= rw;
    rect_height <= rh;
    offset_x    <= ox;
    offset_y    <= oy;
    do @(posedge clk); while (!in_ready);
  endtask

  // start fields are don't-care on an advance, so they get random content
  task automatic send_advance();
    send_word(tba_pkg::REQ_ADVANCE, POS_W'($urandom), POS_W'($urandom),
              SIZE_W'($urandom), SIZE_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  // stop offering and let every queued pair come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_wrap();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(1, 16);
    if (r < 70) return $urandom_range(1, 64);
    return $urandom_range(1, 2047);
  endfunction

  // one start and its advances; long blits get cut short by the next start
  task automatic run_blit(inout int counted);
    logic [SIZE_W-1:0] rw, rh;
    logic [POS_W-1:0]  ox, oy;
    int                pick, area, steps;
    pick = $urandom_range(99);
    if (pick < 75) begin
      rw = SIZE_W'($urandom_range(1, 8));
      rh = SIZE_W'($urandom_range(1, 5));
    end else if (pick < 90) begin
      rw = SIZE_W'($urandom);
      rh = SIZE_W'($urandom);
    end else begin
      rw = SIZE_W'($urandom_range(0, 3));
      rh = SIZE_W'($urandom_range(0, 3));
    end
    if ($urandom_range(99) < 85) begin
      ox = POS_W'($urandom_range(0, cur_w - 1));
      oy = POS_W'($urandom_range(0, cur_h - 1));
    end else begin
      ox = POS_W'($urandom);
      oy = POS_W'($urandom);
    end
    send_word(tba_pkg::REQ_START, POS_W'($urandom), POS_W'($urandom), rw, rh, ox, oy);
    if (int'(ox) >= cur_w || int'(oy) >= cur_h) return;
    counted++;
    area  = int'(rw) * int'(rh);
    steps = (area > LONG_BLIT) ? $urandom_range(1, LONG_BLIT) : area;
    repeat (steps) begin
      send_advance();
      counted++;
    end
    // a stray advance after the walk has ended
    if (area <= LONG_BLIT && $urandom_range(99) < 10) send_advance();
  endtask

  initial begin : stimulus
    int p, phase_words;
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = tba_pkg::REQ_START;
    dest_x        = '0;
    dest_y        = '0;
    rect_width    = '0;
    rect_height   = '0;
    offset_x      = '0;
    offset_y      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = tba_pkg::CFG_DEST_BASE;
    cfg_data      = '0;
    jitter_on     = 1'b1;
    hold_requests = 0;
    cur_w         = 1;
    cur_h         = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: 1x1 bitmap
    send_advance();                                         // advance while idle
    send_word(tba_pkg::REQ_START, 10'd1023, 10'd1023, 11'd1, 11'd1, 10'd0, 10'd0);
    send_advance();                                         // single pair, last
    send_word(tba_pkg::REQ_START, 10'd0, 10'd0, 11'd2, 11'd2, 10'd1, 10'd0);  // ox too big
    send_word(tba_pkg::REQ_START, 10'd0, 10'd0, 11'd2, 11'd2, 10'd0, 10'd1);  // oy too big
    send_advance();
    wait_for_results();

    // oversized wrap registers, all-ones bases and stride
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2047, 2047, 8191);
    send_word(tba_pkg::REQ_START, 10'd0, 10'd0, 11'd2, 11'd2, 10'd1023, 10'd1023);
    repeat (4) send_advance();                              // wraps column and row
    send_word(tba_pkg::REQ_START, 10'd3, 10'd3, 11'd0, 11'd5, 10'd0, 10'd0);  // empty width
    send_advance();
    send_word(tba_pkg::REQ_START, 10'd3, 10'd3, 11'd5, 11'd0, 10'd0, 10'd0);  // empty height
    send_word(tba_pkg::REQ_START, 10'd512, 10'd512, 11'd2047, 11'd2047, 10'd5, 10'd9);
    send_advance();
    send_word(tba_pkg::REQ_START, 10'd1, 10'd2, 11'd1, 11'd1, 10'd0, 10'd0);  // restart midway
    send_advance();
    wait_for_results();

    // zero width: every start is dropped
    program_regs(32'h0, 32'h0, 0, 3, 0);
    send_word(tba_pkg::REQ_START, 10'd0, 10'd0, 11'd1, 11'd1, 10'd0, 10'd0);
    send_advance();
    wait_for_results();

    // random phases, each under its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(32'h0, 32'h0, 3, 2, 0);
        1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1024, 1024, 4096);
        3: program_regs($urandom, $urandom, 1, 1, 1);
        default: program_regs($urandom, $urandom, pick_wrap(), pick_wrap(),
                              $urandom_range(1) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 16));
      endcase
      jitter_on   <= (p != 2);
      phase_words = 0;
      // receiver holds off while a long walk keeps coming in
      if (p == 0) begin
        hold_requests <= hold_requests + 1;
        send_word(tba_pkg::REQ_START, POS_W'($urandom), POS_W'($urandom),
                  11'd16, 11'd4, 10'd0, 10'd0);
        repeat (64) send_advance();
        phase_words += 65;
      end
      while (phase_words < PHASE_WORDS) run_blit(phase_words);
      // empty start leaves the block idle for the next register setting
      send_word(tba_pkg::REQ_START, 10'd0, 10'd0, 11'd0, 11'd0, 10'd0, 10'd0);
      wait_for_results();
    end

    if (mismatches == 0)
      $display("tiled_blit_address_generator_test OK");
    else
      $display("tiled_blit_address_generator_test NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
design/tba_pkg.sv
design/tba_walker.sv
design/tiled_blit_address_generator.sv
tb/sv/blit_pair_checker.sv
tb/sv/tiled_blit_address_generator_test.sv
